FILE: sv/cfd_pkg.sv
// Shared constants, types and arithmetic helpers for the complex FIR decimator.
package cfd_pkg;

  localparam int MAX_TAPS = 511;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int TAP_AW   = 9;
  localparam int DECIM_W  = 7;
  localparam int PHASE_W  = 6;
  localparam int HIST_W   = 2 * SAMPLE_W;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + TAP_AW;
  localparam int DECIM_MAX = 64;
  localparam int TAPS_MIN  = 31;
  localparam int TAPS_PER_DECIM = 16;

  // Input item kinds carried on in_tuser
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Per-cycle control riding along with a MAC read
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Ratio clamped to [1, 64]
  function automatic logic [DECIM_W-1:0] eff_decim(input logic [DECIM_W-1:0] d);
    logic [DECIM_W-1:0] r;
    r = d;
    if (d == '0) r = DECIM_W'(1);
    if (d > DECIM_W'(DECIM_MAX)) r = DECIM_W'(DECIM_MAX);
    return r;
  endfunction

  // Tap count clamp(16*ratio+1, 31, 511)
  function automatic logic [TAP_AW-1:0] tap_count(input logic [DECIM_W-1:0] d);
    logic [DECIM_W+4:0] n;
    n = {eff_decim(d), 4'b0000} + (DECIM_W+5)'(1);
    if (n < (DECIM_W+5)'(TAPS_MIN)) n = (DECIM_W+5)'(TAPS_MIN);
    if (n > (DECIM_W+5)'(MAX_TAPS)) n = (DECIM_W+5)'(MAX_TAPS);
    return n[TAP_AW-1:0];
  endfunction

  // Round half up by 2^(COEF_W-1), then saturate to a sample
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]            r;
    logic signed [ACC_W-COEF_W+1:0]   q;
    logic signed [SAMPLE_W-1:0]       y;
    r = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (COEF_W - 2));
    q = $signed(r[ACC_W:COEF_W-1]);
    if (q > (ACC_W-COEF_W+2)'((1 << (SAMPLE_W - 1)) - 1))
      y = {1'b0, {(SAMPLE_W-1){1'b1}}};
    else if (q < -(ACC_W-COEF_W+2)'(1 << (SAMPLE_W - 1)))
      y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    else
      y = q[SAMPLE_W-1:0];
    return y;
  endfunction

endpackage

FILE: sv/cfd_ram.sv
// Simple dual-port synchronous RAM with registered read.
module cfd_ram #(
  parameter int DEPTH = 511,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/cfd_mac.sv
// Dual multiply-accumulate datapath with rounding and saturation.
module cfd_mac import cfd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic [HIST_W-1:0]          hist_rdata,
  input  logic [COEF_W-1:0]          coef_rdata,
  output logic                       res_rdy,
  output logic signed [SAMPLE_W-1:0] res_i,
  output logic signed [SAMPLE_W-1:0] res_q
);

  mac_ctl_t                 ctl1_r, ctl2_r;
  logic signed [PROD_W-1:0] prod_i_r, prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r, acc_q_r;
  logic signed [ACC_W-1:0]  acc_i_nxt, acc_q_nxt;
  logic                     rdy_r;

  // control delay, aligned with RAM data and products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
    end
  end

  // products, registered
  always_ff @(posedge clk) begin
    prod_i_r <= $signed(coef_rdata) * $signed(hist_rdata[SAMPLE_W-1:0]);
    prod_q_r <= $signed(coef_rdata) * $signed(hist_rdata[HIST_W-1:SAMPLE_W]);
  end

  // accumulate; first tap restarts the sum
  always_comb begin
    acc_i_nxt = acc_i_r;
    acc_q_nxt = acc_q_r;
    if (ctl2_r.vld) begin
      acc_i_nxt = (ctl2_r.first ? '0 : acc_i_r) + ACC_W'(prod_i_r);
      acc_q_nxt = (ctl2_r.first ? '0 : acc_q_r) + ACC_W'(prod_q_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_i_r <= acc_i_nxt;
    acc_q_r <= acc_q_nxt;
  end

  // result ready once the last tap is summed, dropped at the next run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else if (ctl2_r.vld && ctl2_r.last) begin
      rdy_r <= 1'b1;
    end else if (ctl1_r.vld && ctl1_r.first) begin
      rdy_r <= 1'b0;
    end
  end

  assign res_rdy = rdy_r;
  assign res_i   = round_sat(acc_i_r);
  assign res_q   = round_sat(acc_q_r);

endmodule

FILE: sv/cfd_ctrl.sv
// Sequencer: item decode, history bookkeeping, clearing pass and MAC address walk.
module cfd_ctrl import cfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                cfg_valid,
  input  logic [DECIM_W-1:0]  cfg_data,
  output logic                hist_we,
  output logic [TAP_AW-1:0]   hist_waddr,
  output logic [HIST_W-1:0]   hist_wdata,
  output logic                hist_re,
  output logic [TAP_AW-1:0]   hist_raddr,
  output logic                coef_we,
  output logic [TAP_AW-1:0]   coef_waddr,
  output logic [COEF_W-1:0]   coef_wdata,
  output logic                coef_re,
  output logic [TAP_AW-1:0]   coef_raddr,
  output mac_ctl_t            mac_ctl,
  input  logic                res_rdy,
  input  logic                slot_free,
  output logic                res_load
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN} state_t;

  state_t              state_r, state_nxt;
  logic [TAP_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [TAP_AW-1:0]   wr_pos_r, wr_pos_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [DECIM_W-1:0]  decim_r, decim_nxt;
  logic [TAP_AW-1:0]   k_r, k_nxt;
  logic [TAP_AW-1:0]   idx_r, idx_nxt;

  logic                acc_xfer;
  logic [1:0]          opcode;
  logic [TAP_AW-1:0]   tap_index;
  logic [TAP_AW-1:0]   n_taps;
  logic [TAP_AW-1:0]   pos, pos_inc;
  logic [DECIM_W-1:0]  cnt;

  assign opcode    = in_tuser;
  assign tap_index = in_tdata[40:32];
  assign acc_xfer  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign n_taps    = tap_count(decim_r);

  // slot for the new sample and the following write position
  assign pos     = (wr_pos_r >= n_taps) ? '0 : wr_pos_r;
  assign pos_inc = pos + TAP_AW'(1);
  assign cnt     = DECIM_W'(phase_r) + DECIM_W'(1);

  // memory ports
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = pos;
    hist_wdata = in_tdata[HIST_W-1:0];
    coef_we    = 1'b0;
    coef_waddr = tap_index;
    coef_wdata = in_tdata[56:41];
    if (state_r == ST_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr_r;
      hist_wdata = '0;
    end else if (acc_xfer && opcode == OP_PUSH) begin
      hist_we = 1'b1;
    end
    if (acc_xfer && opcode == OP_LOAD && tap_index < TAP_AW'(MAX_TAPS)) begin
      coef_we = 1'b1;
    end
  end

  assign hist_re    = (state_r == ST_MAC);
  assign coef_re    = (state_r == ST_MAC);
  assign hist_raddr = idx_r;
  assign coef_raddr = k_r;

  always_comb begin
    mac_ctl.vld   = (state_r == ST_MAC);
    mac_ctl.first = (k_r == '0);
    mac_ctl.last  = (k_r == n_taps - TAP_AW'(1));
  end

  assign res_load = (state_r == ST_DRAIN) && res_rdy && slot_free;

  // next state
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    wr_pos_nxt   = wr_pos_r;
    phase_nxt    = phase_r;
    decim_nxt    = cfg_valid ? cfg_data : decim_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + TAP_AW'(1);
        if (clr_addr_r == TAP_AW'(MAX_TAPS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc_xfer) begin
          case (opcode)
            OP_PUSH: begin
              wr_pos_nxt = (pos_inc == n_taps) ? '0 : pos_inc;
              if (cnt < eff_decim(decim_r)) begin
                phase_nxt = cnt[PHASE_W-1:0];
              end else begin
                phase_nxt = '0;
                k_nxt     = '0;
                idx_nxt   = pos;
                state_nxt = ST_MAC;
              end
            end
            OP_CLEAR: begin
              wr_pos_nxt   = '0;
              phase_nxt    = '0;
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        // newest sample against tap 0, walking back through the ring
        if (k_r == n_taps - TAP_AW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt   = k_r + TAP_AW'(1);
          idx_nxt = (idx_r == '0) ? n_taps - TAP_AW'(1) : idx_r - TAP_AW'(1);
        end
      end
      ST_DRAIN: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      wr_pos_r   <= '0;
      phase_r    <= '0;
      decim_r    <= DECIM_W'(8);
      k_r        <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      wr_pos_r   <= wr_pos_nxt;
      phase_r    <= phase_nxt;
      decim_r    <= decim_nxt;
      k_r        <= k_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

FILE: sv/complex_fir_decimator.sv
// Top level of the complex FIR decimator: memories, sequencer, MAC and output register.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  in_      | in  | in_tvalid/in_tready  | tdata, tuser = opcode
//  out_     | out | out_tvalid/out_tready| tdata = out_i, out_q
//  cfg_     | in  | cfg_valid/cfg_ready  | cfg_data = decim_factor
//
// A push that does not complete a decimation phase, a coefficient load and an
// unused opcode are each accepted with in_tready staying high. A push that emits
// walks N = clamp(16*ratio+1, 31, 511) taps, one tap per cycle through the single
// read port of the history and coefficient RAMs, then through the MAC pipeline.
// After reset and after a clear the history RAM is swept to zero with in_tready
// low. cfg_ready is always high. A waiting result in the output register only
// stalls the sequencer when the next result is ready to load.
module complex_fir_decimator import cfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_i, sample_q, tap_index, tap_value, zero pad
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_i, out_q
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic                       hist_we, hist_re, coef_we, coef_re;
  logic [TAP_AW-1:0]          hist_waddr, hist_raddr, coef_waddr, coef_raddr;
  logic [HIST_W-1:0]          hist_wdata, hist_rdata;
  logic [COEF_W-1:0]          coef_wdata, coef_rdata;
  mac_ctl_t                   mac_ctl;
  logic                       res_rdy, res_load, slot_free;
  logic signed [SAMPLE_W-1:0] res_i, res_q;
  logic                       out_valid_r;
  logic [HIST_W-1:0]          out_data_r;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_tready;

  cfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_re    (hist_re),
    .hist_raddr (hist_raddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_re    (coef_re),
    .coef_raddr (coef_raddr),
    .mac_ctl    (mac_ctl),
    .res_rdy    (res_rdy),
    .slot_free  (slot_free),
    .res_load   (res_load)
  );

  // complex sample history, {q, i}
  cfd_ram #(.DEPTH(MAX_TAPS), .WIDTH(HIST_W)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // coefficient table
  cfd_ram #(.DEPTH(MAX_TAPS), .WIDTH(COEF_W)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  cfd_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .hist_rdata (hist_rdata),
    .coef_rdata (coef_rdata),
    .res_rdy    (res_rdy),
    .res_i      (res_i),
    .res_q      (res_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= {res_q, res_i};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/cfd_checker.sv
// Port-level checker for the complex FIR decimator, bound to the top level.
module cfd_port_checker import cfd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset starts the history clearing pass, no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not in clearing pass after reset");

  // a clear transfer stops input while the history is swept
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_CLEAR |=> !in_tready)
    else $error("input taken during clearing pass");

  // results are loaded only while the MAC run holds the input off
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared outside a MAC run");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind complex_fir_decimator cfd_port_checker u_cfd_port_checker (.*);
